>>> hdl/cartridge_bank_controller_defines.svh
// ----------------------------------------------------------------------------
// cartridge bank controller assertion macros
// shared concurrent assertion forms, clocked on aclk and held off in reset
// ----------------------------------------------------------------------------
`ifndef CARTRIDGE_BANK_CONTROLLER_DEFINES_SVH
`define CARTRIDGE_BANK_CONTROLLER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define CBC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define CBC_ASSERT_NEXT(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (prop)) \
        else $error(msg);
`else
`define CBC_ASSERT(lbl, prop, msg)
`define CBC_ASSERT_NEXT(lbl, cond, prop, msg)
`endif

`endif

>>> hdl/cbc_pkg.sv
// ----------------------------------------------------------------------------
// cbc_pkg
// types and codes shared by the cartridge bank controller modules
// ----------------------------------------------------------------------------
package cbc_pkg;

    localparam int ADDR_W     = 16;
    localparam int BYTE_W     = 8;
    localparam int ROM_ADDR_W = 22;
    localparam int ROM_OFF_W  = 14;
    localparam int RAM_OFF_W  = 13;
    localparam int SPAN_W     = 15;

    localparam logic [1:0] ST_FETCH   = 2'd0;
    localparam logic [1:0] ST_DATA    = 2'd1;
    localparam logic [1:0] ST_WRITTEN = 2'd2;
    localparam logic [1:0] ST_ILLEGAL = 2'd3;

    localparam logic [1:0] CT_PLAIN = 2'd0;
    localparam logic [1:0] CT_MBC1  = 2'd1;
    localparam logic [1:0] CT_MBC3  = 2'd2;

    localparam logic [1:0] RS_NONE = 2'd0;
    localparam logic [1:0] RS_2K   = 2'd1;
    localparam logic [1:0] RS_8K   = 2'd2;
    localparam logic [1:0] RS_32K  = 2'd3;

    localparam logic [1:0] CFG_CTRL_TYPE = 2'd0;
    localparam logic [1:0] CFG_ROM_SIZE  = 2'd1;
    localparam logic [1:0] CFG_RAM_SIZE  = 2'd2;

    // address bits 15:13
    localparam logic [2:0] RG_ENABLE   = 3'd0;
    localparam logic [2:0] RG_ROM_BANK = 3'd1;
    localparam logic [2:0] RG_RAM_SEL  = 3'd2;
    localparam logic [2:0] RG_MODE     = 3'd3;
    localparam logic [2:0] RG_VRAM     = 3'd4;
    localparam logic [2:0] RG_RAM      = 3'd5;

    localparam logic [3:0] RAM_ON_KEY  = 4'hA;
    localparam logic [7:0] OPEN_BUS    = 8'hFF;
    localparam logic [1:0] RAM_SEL_MAX = 2'd3;

    typedef struct packed {
        logic [1:0] controller_type;
        logic [2:0] rom_size_code;
        logic [1:0] ram_size_code;
    } cfg_t;

    typedef struct packed {
        logic [1:0]            status;
        logic [ROM_ADDR_W-1:0] rom_address;
        logic [BYTE_W-1:0]     read_data;
        logic [BYTE_W-1:0]     wdata;
        logic                  ram_rd;
        logic                  ram_wr;
    } item_t;

endpackage

>>> hdl/cbc_ram.sv
// ----------------------------------------------------------------------------
// cbc_ram
// generic single clock ram, one write port and one registered read port
// ----------------------------------------------------------------------------
module cbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32768
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/cbc_front.sv
// ----------------------------------------------------------------------------
// cbc_front
// accepts bus accesses, decodes regions, updates bank state, maps addresses
// ----------------------------------------------------------------------------
`include "cartridge_bank_controller_defines.svh"

module cbc_front #(
    parameter int RAM_BYTES = 32768
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  cbc_pkg::cfg_t                cfg,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [23:0]                  s_tdata,  // address, write_data
    input  logic [0:0]                   s_tuser,  // operation
    output logic                         push_valid,
    input  logic                         push_ready,
    output cbc_pkg::item_t               push_item,
    output logic [$clog2(RAM_BYTES)-1:0] push_addr
);

    localparam int AW = $clog2(RAM_BYTES);
    localparam int OW = (AW > cbc_pkg::SPAN_W) ? AW : cbc_pkg::SPAN_W;
    localparam logic [OW+3:0] DIVISOR = (OW+4)'(RAM_BYTES);

    logic [7:0] rom_bank_reg, rom_bank_next;
    logic [1:0] ram_sel_reg, ram_sel_next;
    logic       ram_enable_reg, ram_enable_next;
    logic       mode_reg, mode_next;

    logic                        acc;
    logic                        op_wr;
    logic [cbc_pkg::ADDR_W-1:0]  addr;
    logic [cbc_pkg::BYTE_W-1:0]  wd;
    logic [2:0]                  region;
    logic                        illegal;
    logic                        ram_on;
    logic                        is_mbc;
    logic [8:0]                  mask9;
    logic [7:0]                  mask;
    logic [4:0]                  b5;
    logic [6:0]                  b7;
    logic [1:0]                  sel_bank;
    logic [cbc_pkg::SPAN_W-1:0]  off;
    logic [OW+3:0]               rem;

    assign acc      = s_tvalid && s_tready;
    assign s_tready = push_ready;
    assign op_wr    = s_tuser[0];
    assign addr     = s_tdata[15:0];
    assign wd       = s_tdata[23:16];
    assign region   = addr[15:13];
    assign illegal  = (region == cbc_pkg::RG_VRAM) || (region[2:1] == 2'b11);
    assign ram_on   = ram_enable_reg && (cfg.ram_size_code != cbc_pkg::RS_NONE);
    assign is_mbc   = (cfg.controller_type == cbc_pkg::CT_MBC1) ||
                      (cfg.controller_type == cbc_pkg::CT_MBC3);
    assign mask9    = (9'd2 << cfg.rom_size_code) - 9'd1;
    assign mask     = mask9[7:0];
    assign b5       = (wd[4:0] == 5'd0) ? 5'd1 : wd[4:0];
    assign b7       = (wd[6:0] == 7'd0) ? 7'd1 : wd[6:0];

    // bank register writes
    always_comb begin
        rom_bank_next   = rom_bank_reg;
        ram_sel_next    = ram_sel_reg;
        ram_enable_next = ram_enable_reg;
        mode_next       = mode_reg;
        if (acc && op_wr && !illegal && is_mbc && region != cbc_pkg::RG_RAM) begin
            if (cfg.controller_type == cbc_pkg::CT_MBC1) begin
                unique case (region)
                    cbc_pkg::RG_ENABLE: begin
                        ram_enable_next = (wd[3:0] == cbc_pkg::RAM_ON_KEY);
                    end
                    cbc_pkg::RG_ROM_BANK: begin
                        if (mode_reg) begin
                            rom_bank_next = {3'b000, b5} & mask;
                        end else begin
                            rom_bank_next = {rom_bank_reg[7:5], b5} & mask;
                        end
                    end
                    cbc_pkg::RG_RAM_SEL: begin
                        if (mode_reg) begin
                            ram_sel_next = (cfg.ram_size_code == cbc_pkg::RS_32K) ?
                                           wd[1:0] : 2'd0;
                        end else begin
                            rom_bank_next = {1'b0, wd[1:0], rom_bank_reg[4:0]} & mask;
                        end
                    end
                    cbc_pkg::RG_MODE: begin
                        mode_next = wd[0];
                        if (wd[0]) begin
                            rom_bank_next = {3'b000, rom_bank_reg[4:0]};
                        end else begin
                            ram_sel_next = 2'd0;
                        end
                    end
                    default: begin
                    end
                endcase
            end else begin
                unique case (region)
                    cbc_pkg::RG_ENABLE: begin
                        ram_enable_next = (wd[3:0] == cbc_pkg::RAM_ON_KEY);
                    end
                    cbc_pkg::RG_ROM_BANK: begin
                        rom_bank_next = {1'b0, b7} & mask;
                    end
                    cbc_pkg::RG_RAM_SEL: begin
                        if (cfg.ram_size_code != cbc_pkg::RS_32K) begin
                            ram_sel_next = 2'd0;
                        end else if (wd > 8'(cbc_pkg::RAM_SEL_MAX)) begin
                            ram_sel_next = cbc_pkg::RAM_SEL_MAX;
                        end else begin
                            ram_sel_next = wd[1:0];
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rom_bank_reg   <= 8'd1;
            ram_sel_reg    <= 2'd0;
            ram_enable_reg <= 1'b0;
            mode_reg       <= 1'b0;
        end else begin
            rom_bank_reg   <= rom_bank_next;
            ram_sel_reg    <= ram_sel_next;
            ram_enable_reg <= ram_enable_next;
            mode_reg       <= mode_next;
        end
    end

    // ram offset, wrapped to the fitted ram size and then to the ram depth
    always_comb begin
        sel_bank = ((cfg.controller_type == cbc_pkg::CT_MBC3) || mode_reg) ?
                   ram_sel_reg : 2'd0;
        off = {sel_bank, addr[cbc_pkg::RAM_OFF_W-1:0]};
        unique case (cfg.ram_size_code)
            cbc_pkg::RS_2K:  off = {4'd0, off[10:0]};
            cbc_pkg::RS_8K:  off = {2'd0, off[12:0]};
            cbc_pkg::RS_32K: off = off;
            default:         off = '0;
        endcase
        rem = (OW+4)'(off);
        for (int k = 3; k >= 0; k--) begin
            if (rem >= (DIVISOR << k)) begin
                rem = rem - (DIVISOR << k);
            end
        end
    end

    // result classification
    always_comb begin
        push_item = '0;
        push_item.wdata = wd;
        if (illegal) begin
            push_item.status = cbc_pkg::ST_ILLEGAL;
        end else if (op_wr) begin
            push_item.status = cbc_pkg::ST_WRITTEN;
            push_item.ram_wr = is_mbc && (region == cbc_pkg::RG_RAM) && ram_on;
        end else if (region == cbc_pkg::RG_RAM) begin
            push_item.status    = cbc_pkg::ST_DATA;
            push_item.ram_rd    = ram_on;
            push_item.read_data = ram_on ? 8'h00 : cbc_pkg::OPEN_BUS;
        end else if (region[2:1] == 2'b00) begin
            push_item.status      = cbc_pkg::ST_FETCH;
            push_item.rom_address = cbc_pkg::ROM_ADDR_W'(addr);
        end else begin
            push_item.status      = cbc_pkg::ST_FETCH;
            push_item.rom_address = {rom_bank_reg, addr[cbc_pkg::ROM_OFF_W-1:0]};
        end
    end

    assign push_valid = s_tvalid;
    assign push_addr  = rem[AW-1:0];

    `CBC_ASSERT_NEXT(a_plain_write_keeps_banks,
        acc && op_wr && cfg.controller_type == cbc_pkg::CT_PLAIN,
        $stable(rom_bank_reg) && $stable(ram_sel_reg) &&
        $stable(ram_enable_reg) && $stable(mode_reg),
        "plain rom write changed bank state")
    `CBC_ASSERT_NEXT(a_illegal_keeps_banks, acc && illegal,
        $stable(rom_bank_reg) && $stable(ram_sel_reg) &&
        $stable(ram_enable_reg) && $stable(mode_reg),
        "unmapped access changed bank state")
    `CBC_ASSERT(a_enable_from_write,
        $rose(ram_enable_reg) |-> $past(acc && op_wr),
        "ram enable rose without a write transfer")

endmodule

>>> hdl/cbc_queue.sv
// ----------------------------------------------------------------------------
// cbc_queue
// short fifo between the decode front and the memory back
// ----------------------------------------------------------------------------
`include "cartridge_bank_controller_defines.svh"

module cbc_queue #(
    parameter int DATA_W = 64,
    parameter int DEPTH  = 2
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [DATA_W-1:0] in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DATA_W-1:0] out_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] slot_reg [DEPTH];
    logic [PW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic              push;
    logic              pop;

    assign in_ready  = (cnt_reg != CW'(DEPTH));
    assign out_valid = (cnt_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_data  = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_data;
        end
    end

    `CBC_ASSERT(a_cnt_bound, cnt_reg <= CW'(DEPTH), "queue count above depth")
    `CBC_ASSERT_NEXT(a_cnt_up, push && !pop, cnt_reg == $past(cnt_reg) + 1'b1,
        "queue count did not grow on push")
    `CBC_ASSERT_NEXT(a_cnt_down, pop && !push, cnt_reg == $past(cnt_reg) - 1'b1,
        "queue count did not shrink on pop")

endmodule

>>> hdl/cbc_back.sv
// ----------------------------------------------------------------------------
// cbc_back
// performs banked ram accesses and holds the result for the master side
// ----------------------------------------------------------------------------
module cbc_back #(
    parameter int RAM_BYTES = 32768
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         q_valid,
    output logic                         q_ready,
    input  cbc_pkg::item_t               q_item,
    input  logic [$clog2(RAM_BYTES)-1:0] q_addr,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [31:0]                  m_tdata,  // rom_address, read_data
    output logic [1:0]                   m_tuser   // status
);

    logic                       out_valid_reg, out_valid_next;
    cbc_pkg::item_t             out_item_reg;
    logic                       pop;
    logic [cbc_pkg::BYTE_W-1:0] ram_rdata;
    logic [cbc_pkg::BYTE_W-1:0] rd_byte;

    assign q_ready = !out_valid_reg || m_tready;
    assign pop     = q_valid && q_ready;

    cbc_ram #(
        .WIDTH (cbc_pkg::BYTE_W),
        .DEPTH (RAM_BYTES)
    ) u_ram (
        .aclk  (aclk),
        .we    (pop && q_item.ram_wr),
        .waddr (q_addr),
        .wdata (q_item.wdata),
        .re    (pop && q_item.ram_rd),
        .raddr (q_addr),
        .rdata (ram_rdata)
    );

    always_comb begin
        out_valid_next = out_valid_reg;
        if (pop) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            out_item_reg <= q_item;
        end
    end

    assign rd_byte  = out_item_reg.ram_rd ? ram_rdata : out_item_reg.read_data;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, rd_byte, out_item_reg.rom_address};
    assign m_tuser  = out_item_reg.status;

endmodule

>>> hdl/cartridge_bank_controller.sv
// ----------------------------------------------------------------------------
// cartridge_bank_controller
// mbc1 / mbc3 style bank controller with internal banked cartridge ram
// ----------------------------------------------------------------------------
// usage: each s_ transfer is one cpu bus access (s_tuser = write flag,
// s_tdata = address and write byte). every access gives exactly one m_
// transfer: m_tuser is the status (rom fetch, read data, write done,
// illegal address), m_tdata carries the rom fetch address and the read byte.
// cfg_ writes set controller type, rom size and ram size; issue them only
// while no access is in flight. cfg_ready is always high.
// each access passes the queue, then the output register. throughput: one
// access per cycle while m_tready is high; the front decodes and updates the
// bank registers in the accept cycle, the back does one ram port access per
// cycle. a two entry queue sits between them; when m_tready is low the output
// register holds, the queue fills and s_tready drops after two more accesses.
// reset (aresetn low, synchronous): rom bank 1, ram bank 0, ram disabled,
// rom banking mode, config registers zero, queue and output empty. ram
// contents are not cleared and read back undefined until written.
// ----------------------------------------------------------------------------
module cartridge_bank_controller #(
    parameter int RAM_BYTES = 32768
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,  // address[15:0], write_data[23:16]
    input  logic [0:0]  s_tuser,  // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,  // rom_address[21:0], read_data[29:22], zero
    output logic [1:0]  m_tuser   // status
);

    localparam int AW     = $clog2(RAM_BYTES);
    localparam int ITEM_W = $bits(cbc_pkg::item_t);
    localparam int Q_W    = ITEM_W + AW;

    cbc_pkg::cfg_t   cfg_reg, cfg_next;
    logic            push_valid;
    logic            push_ready;
    cbc_pkg::item_t  push_item;
    logic [AW-1:0]   push_addr;
    logic            q_valid;
    logic            q_ready;
    logic [Q_W-1:0]  q_data;
    cbc_pkg::item_t  q_item;
    logic [AW-1:0]   q_addr;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                cbc_pkg::CFG_CTRL_TYPE: cfg_next.controller_type = cfg_data[1:0];
                cbc_pkg::CFG_ROM_SIZE:  cfg_next.rom_size_code   = cfg_data[2:0];
                cbc_pkg::CFG_RAM_SIZE:  cfg_next.ram_size_code   = cfg_data[1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    cbc_front #(
        .RAM_BYTES (RAM_BYTES)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .push_addr  (push_addr)
    );

    cbc_queue #(
        .DATA_W (Q_W),
        .DEPTH  (2)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_data   ({push_addr, push_item}),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_data)
    );

    assign q_item = cbc_pkg::item_t'(q_data[ITEM_W-1:0]);
    assign q_addr = q_data[Q_W-1:ITEM_W];

    cbc_back #(
        .RAM_BYTES (RAM_BYTES)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item),
        .q_addr   (q_addr),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
